/* hdl/arpc_pkg.sv */
`default_nettype none

package arpc_pkg;

    // Number of table entries, and hence cells in the chain.
    localparam int ENTRIES = 16;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OWN_IP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC = 4'd1;

    localparam logic [31:0] RESET_OWN_IP = 32'h0A00_020F;

    // ARP operation codes.
    localparam logic [15:0] OPER_REQUEST = 16'd1;
    localparam logic [15:0] OPER_REPLY   = 16'd2;

    // Input command codes.
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result kinds.
    localparam logic [2:0] KIND_IGNORED = 3'd0;
    localparam logic [2:0] KIND_REPLY   = 3'd1;
    localparam logic [2:0] KIND_STORED  = 3'd2;
    localparam logic [2:0] KIND_FULL    = 3'd3;
    localparam logic [2:0] KIND_HIT     = 3'd4;
    localparam logic [2:0] KIND_MISS    = 3'd5;

    typedef struct packed {
        logic        command;
        logic [15:0] arp_oper;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [31:0] tgt_ip;
        logic [31:0] query_ip;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [47:0] reply_dst_mac;
        logic [31:0] reply_dst_ip;
        logic [47:0] found_mac;
    } t_out_item;

    // Operation travelling along the chain of cells. On an insert, mac holds
    // the MAC to store; on a lookup it collects the MAC of the matching entry.
    typedef struct packed {
        logic        active;
        logic        lookup;
        logic        done;
        logic [31:0] ip;
        logic [47:0] mac;
    } t_token;

endpackage

`default_nettype wire

/* hdl/arpc_cell.sv */
`default_nettype none

module arpc_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire arpc_pkg::t_token i_tok,
    output arpc_pkg::t_token     o_tok
);

    logic             r_valid;
    logic [31:0]      r_ip;
    logic [47:0]      r_mac;
    arpc_pkg::t_token r_tok;
    arpc_pkg::t_token n_tok;

    logic w_pending;
    logic w_hit;
    logic w_ins;

    assign w_pending = i_tok.active && !i_tok.done;
    assign w_hit     = w_pending && i_tok.lookup && r_valid && (r_ip == i_tok.ip);
    assign w_ins     = w_pending && !i_tok.lookup && !r_valid;

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.done = 1'b1;
            n_tok.mac  = r_mac;
        end else if (w_ins) begin
            n_tok.done = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (w_ins) begin
                r_valid <= 1'b1;
            end
        end
    end

    // Entry contents need no reset: they are only read behind r_valid.
    always_ff @(posedge i_clk) begin
        if (w_ins) begin
            r_ip  <= i_tok.ip;
            r_mac <= i_tok.mac;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* hdl/arp_responder_and_cache_top.sv */
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_data  (arpc_pkg::t_in_item)
// out       output     o_out_valid / i_out_stall o_out_data (arpc_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A lookup or an ARP reply walks the ENTRIES cells one per cycle, and its result is
// registered as it leaves the last cell; anything else is registered at acceptance.
// One transaction is in flight at a time; the next input is taken while the
// previous result still waits in the output register.
// Reset is synchronous and active low; it clears every entry's valid bit.
// A stalled output holds its payload; configuration is always ready.
`default_nettype none

module arp_responder_and_cache_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire arpc_pkg::t_in_item          i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output arpc_pkg::t_out_item              o_out_data,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [arpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire [47:0]                       i_cfg_data
);

    // Own IP register. The own MAC index is accepted as a write, but no
    // result field carries it, so it is not held here.
    logic [31:0] r_own_ip;

    // r_busy is set from acceptance of a transaction until its result has
    // moved into the output register.
    logic                r_busy;
    arpc_pkg::t_token    r_launch;
    arpc_pkg::t_out_item r_res;
    logic                r_res_ready;
    arpc_pkg::t_out_item r_out;
    logic                r_out_valid;

    arpc_pkg::t_token    w_tok [arpc_pkg::ENTRIES+1];
    arpc_pkg::t_token    w_end;
    arpc_pkg::t_out_item w_imm;
    arpc_pkg::t_out_item w_chain_res;
    logic                w_accept;
    logic                w_scan;
    logic                w_move;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_busy;
    assign w_accept    = i_in_valid && !r_busy;

    // Lookups and ARP replies need the table; everything else is decided here.
    assign w_scan = (i_in_data.command == arpc_pkg::CMD_LOOKUP) ||
                    (i_in_data.arp_oper == arpc_pkg::OPER_REPLY);

    always_comb begin
        w_imm = '0;
        if ((i_in_data.arp_oper == arpc_pkg::OPER_REQUEST) &&
            (i_in_data.tgt_ip == r_own_ip)) begin
            w_imm.result_kind   = arpc_pkg::KIND_REPLY;
            w_imm.reply_dst_mac = i_in_data.sender_mac;
            w_imm.reply_dst_ip  = i_in_data.sender_ip;
        end else begin
            w_imm.result_kind   = arpc_pkg::KIND_IGNORED;
        end
    end

    // The chain: cell 0 takes the launched token, the last cell hands it back.
    assign w_tok[0] = r_launch;

    for (genvar g = 0; g < arpc_pkg::ENTRIES; g++) begin : g_cell
        arpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_end = w_tok[arpc_pkg::ENTRIES];

    always_comb begin
        w_chain_res = '0;
        if (w_end.lookup) begin
            if (w_end.done) begin
                w_chain_res.result_kind = arpc_pkg::KIND_HIT;
                w_chain_res.found_mac   = w_end.mac;
            end else begin
                w_chain_res.result_kind = arpc_pkg::KIND_MISS;
            end
        end else begin
            w_chain_res.result_kind = w_end.done ? arpc_pkg::KIND_STORED
                                                 : arpc_pkg::KIND_FULL;
        end
    end

    // The held result moves on once the output register is free or draining.
    assign w_move = r_res_ready && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip        <= arpc_pkg::RESET_OWN_IP;
            r_busy          <= 1'b0;
            r_launch.active <= 1'b0;
            r_res_ready     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid && (i_cfg_index == arpc_pkg::REG_OWN_IP)) begin
                r_own_ip <= i_cfg_data[31:0];
            end

            r_launch.active <= 1'b0;
            if (w_accept) begin
                r_busy <= 1'b1;
                if (w_scan) begin
                    r_launch.active <= 1'b1;
                    r_launch.lookup <= (i_in_data.command == arpc_pkg::CMD_LOOKUP);
                    r_launch.done   <= 1'b0;
                    if (i_in_data.command == arpc_pkg::CMD_LOOKUP) begin
                        r_launch.ip  <= i_in_data.query_ip;
                        r_launch.mac <= '0;
                    end else begin
                        r_launch.ip  <= i_in_data.sender_ip;
                        r_launch.mac <= i_in_data.sender_mac;
                    end
                end else begin
                    r_res       <= w_imm;
                    r_res_ready <= 1'b1;
                end
            end else if (w_end.active) begin
                r_res       <= w_chain_res;
                r_res_ready <= 1'b1;
            end else if (w_move) begin
                r_res_ready <= 1'b0;
                r_busy      <= 1'b0;
            end

            if (w_move) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    // A held result always belongs to a transaction still in flight.
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_ready |-> r_busy)
        else $error("held result without a transaction in flight");

    // A token leaving the chain never finds the holding register occupied.
    a_end_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end.active |-> !r_res_ready)
        else $error("chain result would overwrite a held result");

    // When idle, nothing is left travelling along the chain.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (!w_end.active && !r_launch.active))
        else $error("token in the chain while idle");

    // Acceptance either launches a token or holds a result at once.
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_busy && (r_launch.active || r_res_ready)))
        else $error("accepted transaction produced no work");
`endif

endmodule

`default_nettype wire

/* tb/arp_responder_and_cache_top_tb.sv */
// Mirror of the responder and address cache, kept in step with the block.
// Each accepted transaction is turned into the result that the block owes,
// and results leaving the block are compared against those in order.
class t_arp_cache_mirror;
    bit [31:0]           own_ip = arpc_pkg::RESET_OWN_IP;
    bit [47:0]           own_mac;
    bit [31:0]           ip_tab  [arpc_pkg::ENTRIES];
    bit [47:0]           mac_tab [arpc_pkg::ENTRIES];
    bit                  held    [arpc_pkg::ENTRIES];
    int                  fill;
    arpc_pkg::t_out_item due_answers[$];
    int                  items_taken;
    int                  answers_seen;
    int                  kind_tally [8];
    int                  faults;

    function void write_reg(logic [arpc_pkg::CFG_IDX_W-1:0] idx, logic [47:0] val);
        case (idx)
            arpc_pkg::REG_OWN_IP:  own_ip = val[31:0];
            arpc_pkg::REG_OWN_MAC: own_mac = val;
            default: ;
        endcase
    endfunction

    function void accept_item(arpc_pkg::t_in_item it);
        arpc_pkg::t_out_item ans;
        int slot;
        ans = '0;
        slot = -1;
        items_taken++;
        if (it.command == arpc_pkg::CMD_LOOKUP) begin
            // Scanning downwards leaves the lowest-numbered match in slot.
            for (int i = arpc_pkg::ENTRIES - 1; i >= 0; i--)
                if (held[i] && ip_tab[i] == it.query_ip) slot = i;
            ans.result_kind = arpc_pkg::KIND_MISS;
            if (slot >= 0) begin
                ans.result_kind = arpc_pkg::KIND_HIT;
                ans.found_mac   = mac_tab[slot];
            end
        end else if (it.arp_oper == arpc_pkg::OPER_REQUEST) begin
            ans.result_kind = arpc_pkg::KIND_IGNORED;
            if (it.tgt_ip == own_ip) begin
                ans.result_kind   = arpc_pkg::KIND_REPLY;
                ans.reply_dst_mac = it.sender_mac;
                ans.reply_dst_ip  = it.sender_ip;
            end
        end else if (it.arp_oper == arpc_pkg::OPER_REPLY) begin
            for (int i = arpc_pkg::ENTRIES - 1; i >= 0; i--)
                if (!held[i]) slot = i;
            ans.result_kind = arpc_pkg::KIND_FULL;
            if (slot >= 0) begin
                ip_tab[slot]    = it.sender_ip;
                mac_tab[slot]   = it.sender_mac;
                held[slot]      = 1'b1;
                fill++;
                ans.result_kind = arpc_pkg::KIND_STORED;
            end
        end else begin
            ans.result_kind = arpc_pkg::KIND_IGNORED;
        end
        due_answers.push_back(ans);
    endfunction

    function void check_answer(arpc_pkg::t_out_item got);
        arpc_pkg::t_out_item want;
        answers_seen++;
        if (due_answers.size() == 0) begin
            faults++;
            if (faults <= 10)
                $display("%0t: result with nothing outstanding: %h", $realtime, got);
            return;
        end
        want = due_answers.pop_front();
        kind_tally[want.result_kind]++;
        if (got.result_kind !== want.result_kind || got.reply_dst_mac !== want.reply_dst_mac ||
            got.reply_dst_ip !== want.reply_dst_ip || got.found_mac !== want.found_mac) begin
            faults++;
            if (faults <= 10)
                $display("%0t: result %0d (expected/actual) kind %0d/%0d reply mac %h/%h",
                         $realtime, answers_seen, want.result_kind, got.result_kind,
                         want.reply_dst_mac, got.reply_dst_mac,
                         "\n    reply ip %h/%h found mac %h/%h",
                         want.reply_dst_ip, got.reply_dst_ip, want.found_mac, got.found_mac);
        end
    endfunction
endclass

module arp_responder_and_cache_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Packet operations that the block must ignore: none at all, and RARP request.
    localparam logic [15:0] OPER_NONE = 16'h0000;
    localparam logic [15:0] OPER_RARP = 16'h0003;

    // Register indexes beyond the two real registers; writes there must be dropped.
    localparam logic [arpc_pkg::CFG_IDX_W-1:0] REG_SPARE = 4'd2;
    localparam logic [arpc_pkg::CFG_IDX_W-1:0] REG_LAST  = 4'd15;

    // Length of the deliberate output hold, and the watchdog limit in cycles. The
    // slowest correct run is roughly 1200 transactions.
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 500000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    arpc_pkg::t_in_item             i_in_data = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    arpc_pkg::t_out_item            o_out_data;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [arpc_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [47:0]                    i_cfg_data = '0;

    t_arp_cache_mirror mirror = new;

    // Percentages for the sender's gaps and the receiver's stalls in the current phase.
    int send_idle_pct = 0;
    int stall_pct = 0;

    // A long hold is requested by bumping hold_asks; the receiver process counts it out.
    int hold_asks = 0;
    int hold_served = 0;
    int hold_left = 0;

    int unsigned cycle_count = 0;

    arp_responder_and_cache_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // The watchdog. A correct block finishes far inside this limit, so reaching
    // it means that something has hung.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, mirror.due_answers.size());
            $display("arp_responder_and_cache_top_tb: FAIL");
            $finish;
        end
    end

    // The receiving side. Either it is counting out a requested long hold, or it
    // stalls at random according to the current phase.
    always @(posedge i_clk) begin
        if (hold_asks != hold_served) begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Every result transaction is checked against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            mirror.check_answer(o_out_data);
    end

    function automatic logic [47:0] any_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic arpc_pkg::t_in_item pkt(logic cmd, logic [15:0] oper, logic [31:0] sip,
                                               logic [47:0] smac, logic [31:0] tip,
                                               logic [31:0] qip);
        arpc_pkg::t_in_item it;
        it.command    = cmd;
        it.arp_oper   = oper;
        it.sender_ip  = sip;
        it.sender_mac = smac;
        it.tgt_ip     = tip;
        it.query_ip   = qip;
        return it;
    endfunction

    // A random transaction. Most are well formed: lookups aimed mainly at addresses
    // already in the table (or one bit away from them), requests aimed mainly at our
    // own address, and replies that sometimes repeat a stored address. The remainder
    // are packets with an arbitrary operation code. Fields that the block should
    // ignore are always filled with random values.
    function automatic arpc_pkg::t_in_item random_item();
        arpc_pkg::t_in_item it;
        int unsigned        roll;
        logic [31:0]        near;
        it = pkt(arpc_pkg::CMD_PACKET, 16'($urandom_range(0, 16'hFFFF)), $urandom, any_mac(),
                 $urandom, $urandom);
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            it.command = arpc_pkg::CMD_LOOKUP;
            if (mirror.fill != 0 && $urandom_range(0, 99) < 70) begin
                near = mirror.ip_tab[$urandom_range(0, mirror.fill - 1)];
                if ($urandom_range(0, 4) == 0)
                    near = near ^ (32'd1 << $urandom_range(0, 31));
                it.query_ip = near;
            end
        end else if (roll < 65) begin
            it.arp_oper = arpc_pkg::OPER_REQUEST;
            case ($urandom_range(0, 3))
                0, 1: it.tgt_ip = mirror.own_ip;
                2: it.tgt_ip = mirror.own_ip ^ (32'd1 << $urandom_range(0, 31));
                default: ;
            endcase
        end else if (roll < 90) begin
            it.arp_oper = arpc_pkg::OPER_REPLY;
            if (mirror.fill != 0 && $urandom_range(0, 4) == 0)
                it.sender_ip = mirror.ip_tab[$urandom_range(0, mirror.fill - 1)];
        end
        return it;
    endfunction

    // Offers one input transaction and returns at the edge where it is taken. The
    // valid is left high so that a following transaction can go out back to back;
    // it is only lowered here when a gap is chosen, or by drain.
    task automatic offer(input arpc_pkg::t_in_item it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        mirror.accept_item(it);
    endtask

    // Waits until every outstanding result has arrived, then a little longer so that
    // the block is certainly idle before the registers are touched.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (mirror.due_answers.size() != 0) @(posedge i_clk);
        repeat (arpc_pkg::ENTRIES + 4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [arpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        mirror.write_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall);
        send_idle_pct = idle_pct;
        stall_pct <= stall;
        repeat (count) offer(random_item());
        drain();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed transactions with the reset register values and no idling. The
        // table is empty at first, so the opening lookup must miss.
        offer(pkt(arpc_pkg::CMD_LOOKUP, OPER_NONE, '0, '0, '0, '0));
        // A request for our own address from an all-ones sender must be answered.
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REQUEST, '1, '1,
                  arpc_pkg::RESET_OWN_IP, '1));
        // A request for another host, one bit away from us, is ignored.
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REQUEST, 32'h0A00_0201,
                  48'h0200_0000_0001, arpc_pkg::RESET_OWN_IP ^ 32'h1, '0));
        // Unknown operations are ignored even when aimed at our address.
        offer(pkt(arpc_pkg::CMD_PACKET, OPER_NONE, 32'h0A00_0202, any_mac(),
                  arpc_pkg::RESET_OWN_IP, '0));
        offer(pkt(arpc_pkg::CMD_PACKET, OPER_RARP, 32'h0A00_0203, any_mac(),
                  arpc_pkg::RESET_OWN_IP, '0));
        offer(pkt(arpc_pkg::CMD_PACKET, '1, '1, '1, arpc_pkg::RESET_OWN_IP, '1));
        // Replies fill the first entries, including the all-zero and all-ones
        // addresses, followed by a duplicate address with a different MAC.
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REPLY, '0, '0, '1, '1));
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REPLY, '1, '1, '0, '0));
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REPLY, 32'h0A00_0201,
                  48'h5254_0012_3502, $urandom, '0));
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REPLY, 32'h0A00_0201,
                  48'hA5A5_5A5A_0F0F, $urandom, '0));
        // Lookups of the extremes, with the packet fields set to look like a request
        // for us; they must be ignored on a lookup.
        offer(pkt(arpc_pkg::CMD_LOOKUP, arpc_pkg::OPER_REQUEST, '1, '1,
                  arpc_pkg::RESET_OWN_IP, '0));
        offer(pkt(arpc_pkg::CMD_LOOKUP, arpc_pkg::OPER_REQUEST, '1, '1,
                  arpc_pkg::RESET_OWN_IP, '1));
        // The duplicate address must resolve to the earlier entry's MAC.
        offer(pkt(arpc_pkg::CMD_LOOKUP, arpc_pkg::OPER_REPLY, $urandom, any_mac(), $urandom,
                  32'h0A00_0201));
        offer(pkt(arpc_pkg::CMD_LOOKUP, arpc_pkg::OPER_REPLY, $urandom, any_mac(), $urandom,
                  32'h0A00_0202));
        // On packets the query address plays no part.
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REQUEST, 32'hC0A8_0001,
                  48'h0011_2233_4455, arpc_pkg::RESET_OWN_IP, '1));
        offer(pkt(arpc_pkg::CMD_PACKET, arpc_pkg::OPER_REPLY, 32'hC0A8_0002, any_mac(), '0,
                  32'h0A00_0201));
        drain();

        // All-ones registers, with the sender idling for much of the time. Random
        // replies fill the table early in this phase, after which they are dropped.
        write_cfg(arpc_pkg::REG_OWN_IP, 48'h0000_FFFF_FFFF);
        write_cfg(arpc_pkg::REG_OWN_MAC, '1);
        run_random(300, 58, 0);

        // All-zero registers, and writes to indexes that do not exist, which must
        // leave both registers alone. The receiver stalls often here.
        write_cfg(arpc_pkg::REG_OWN_IP, '0);
        write_cfg(arpc_pkg::REG_OWN_MAC, '0);
        write_cfg(REG_SPARE, '1);
        write_cfg(REG_LAST, any_mac());
        run_random(300, 0, 58);

        // Random registers; the upper data bits of the address write must be dropped.
        write_cfg(arpc_pkg::REG_OWN_IP, any_mac() | 48'hFFFF_0000_0000);
        write_cfg(arpc_pkg::REG_OWN_MAC, any_mac());

        // Back pressure: the receiver holds off for a long stretch while the sender
        // keeps offering, so the block fills up and has to stall its input.
        send_idle_pct = 0;
        stall_pct <= 0;
        hold_asks <= hold_asks + 1;
        repeat (24) offer(random_item());
        drain();
        run_random(300, 12, 12);

        // The reset address once more, written with junk in the upper data bits.
        write_cfg(arpc_pkg::REG_OWN_IP, {16'hFFFF, arpc_pkg::RESET_OWN_IP});
        run_random(276, 0, 0);

        $display("Checked %0d results for %0d transactions: %0d replies, %0d stored, %0d dropped",
                 mirror.answers_seen, mirror.items_taken,
                 mirror.kind_tally[arpc_pkg::KIND_REPLY],
                 mirror.kind_tally[arpc_pkg::KIND_STORED],
                 mirror.kind_tally[arpc_pkg::KIND_FULL]);
        $display("on a full table, %0d hits, %0d misses, %0d ignored; %0d mismatches.",
                 mirror.kind_tally[arpc_pkg::KIND_HIT], mirror.kind_tally[arpc_pkg::KIND_MISS],
                 mirror.kind_tally[arpc_pkg::KIND_IGNORED], mirror.faults);
        if (mirror.faults == 0 && mirror.due_answers.size() == 0) begin
            $display("arp_responder_and_cache_top_tb: PASS");
        end else begin
            $display("arp_responder_and_cache_top_tb: FAIL");
        end
        $finish;
    end
endmodule

/* arp_responder_and_cache_top.f */
hdl/arpc_pkg.sv
hdl/arpc_cell.sv
hdl/arp_responder_and_cache_top.sv
tb/arp_responder_and_cache_top_tb.sv
